>>> hw/rtl/mim_pkg.sv
// Package: sizes, request and response words, state and control types for the multiplier.
package mim_pkg;

	localparam int MAX_WORDS  = 32;
	localparam int PROD_WORDS = 2 * MAX_WORDS;
	localparam int WORD_W     = 32;
	localparam int IDX_W      = 6;
	localparam int CFG_W      = 6;
	localparam int OA_W       = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int PA_W       = $clog2(PROD_WORDS);
	localparam int LEN_W      = $clog2(MAX_WORDS + 1);

	localparam logic CFG_A_WORDS = 1'b0;
	localparam logic CFG_B_WORDS = 1'b1;

	typedef enum logic [1:0] {
		REQ_LOAD_A = 2'd0,
		REQ_LOAD_B = 2'd1,
		REQ_MUL    = 2'd2,
		REQ_READ   = 2'd3
	} req_type_t;

	typedef struct packed {
		req_type_t          req_type;
		logic [IDX_W-1:0]   word_index;
		logic [WORD_W-1:0]  word_value;
	} mim_req_t;

	typedef struct packed {
		logic [WORD_W-1:0]  result_word;
		logic               done_res;
	} mim_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_FETCH,
		ST_MULT,
		ST_ACC,
		ST_CARRY,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic mul_en;
		logic acc_en;
		logic carry_clr;
	} mac_ctl_t;

	// operand length from its register, saturated to the store depth
	function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_W-1:0] v);
		if (int'(v) > MAX_WORDS) begin
			return LEN_W'(MAX_WORDS);
		end
		return LEN_W'(v);
	endfunction

endpackage

>>> hw/rtl/mim_opnd_store.sv
// Multiplicand and multiplier word memories, one write port, registered reads.
module mim_opnd_store
	import mim_pkg::*;
(
	input  logic              clk,
	input  logic              we_a,
	input  logic              we_b,
	input  logic [OA_W-1:0]   waddr,
	input  logic [WORD_W-1:0] wdata,
	input  logic [OA_W-1:0]   raddr_a,
	input  logic [OA_W-1:0]   raddr_b,
	output logic [WORD_W-1:0] rdata_a,
	output logic [WORD_W-1:0] rdata_b
);

	logic [WORD_W-1:0] mem_a [MAX_WORDS];
	logic [WORD_W-1:0] mem_b [MAX_WORDS];
	logic [WORD_W-1:0] rd_a_q;
	logic [WORD_W-1:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (we_a) begin
			mem_a[waddr] <= wdata;
		end
		rd_a_q <= mem_a[raddr_a];
	end

	always_ff @(posedge clk) begin
		if (we_b) begin
			mem_b[waddr] <= wdata;
		end
		rd_b_q <= mem_b[raddr_b];
	end

	assign rdata_a = rd_a_q;
	assign rdata_b = rd_b_q;

endmodule

>>> hw/rtl/mim_prod_store.sv
// Product word memory with per-word valid bits; an invalid word reads as zero.
module mim_prod_store
	import mim_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clr,
	input  logic              we,
	input  logic [PA_W-1:0]   waddr,
	input  logic [WORD_W-1:0] wdata,
	input  logic              re,
	input  logic [PA_W-1:0]   raddr,
	output logic [WORD_W-1:0] rdata
);

	logic [WORD_W-1:0]     mem [PROD_WORDS];
	logic [PROD_WORDS-1:0] valid_q;
	logic [WORD_W-1:0]     data_q;
	logic                  vld_rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			if (clr) begin
				valid_q <= '0;
			end else if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (re) begin
				vld_rd_q <= valid_q[raddr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			data_q <= mem[raddr];
		end
	end

	assign rdata = vld_rd_q ? data_q : '0;

endmodule

>>> hw/rtl/mim_mac.sv
// Shared multiply-accumulate unit: 32x32 product register, then 64-bit add with carry word.
module mim_mac
	import mim_pkg::*;
(
	input  logic              clk,
	input  mac_ctl_t          ctl,
	input  logic [WORD_W-1:0] a_word,
	input  logic [WORD_W-1:0] b_word,
	input  logic [WORD_W-1:0] p_word,
	output logic [WORD_W-1:0] sum_lo,
	output logic [WORD_W-1:0] carry
);

	logic [2*WORD_W-1:0] prod_q;
	logic [WORD_W-1:0]   carry_q;
	logic [2*WORD_W-1:0] sum;

	// cannot overflow: (2^32-1)^2 + 2*(2^32-1) = 2^64-1
	assign sum = prod_q + {{WORD_W{1'b0}}, p_word} + {{WORD_W{1'b0}}, carry_q};

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_q <= {{WORD_W{1'b0}}, a_word} * {{WORD_W{1'b0}}, b_word};
		end
		if (ctl.carry_clr) begin
			carry_q <= '0;
		end else if (ctl.acc_en) begin
			carry_q <= sum[2*WORD_W-1:WORD_W];
		end
	end

	assign sum_lo = sum[WORD_W-1:0];
	assign carry  = carry_q;

endmodule

>>> hw/rtl/multiword_integer_multiplier_core.sv
// Top level: request decode, multiply sequencer, config registers and response register.
//
// Multiword unsigned multiplier, operands as little-endian arrays of 32-bit words.
// A request word on req is taken at a clock edge with start high and busy low.
// Loads write one operand word; a read returns one product word; a multiply
// clears the product and runs the schoolbook loop over all word pairs.
// Every request gives one response word on rsp, shown for one cycle with
// rsp_valid high; the receiver cannot stall it.
// Each word pair runs through the one shared multiply-accumulate unit in order:
// operand and product fetch from the registered memories, multiply, then add
// and write back; each row ends with one carry write-back.
// busy is high for the whole of a read or multiply; loads keep it low and
// may follow back to back.
// The lengths a_words and b_words arrive on cfg_we/cfg_index/cfg_wdata; the user must
// write them only while idle, unchecked by the block. Reset sets both lengths to 1 and
// zeroes the product at once by valid bits; operand words are undefined until loaded.
module multiword_integer_multiplier_core
	import mim_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  mim_req_t         req,
	output logic             rsp_valid,
	output mim_rsp_t         rsp,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata
);

	state_t            state_q, state_d;
	logic [CFG_W-1:0]  a_words_q, b_words_q;
	logic [OA_W-1:0]   i_q, j_q;
	logic              rd_ok_q;
	logic              rsp_valid_q;
	mim_rsp_t          rsp_q;

	logic [LEN_W-1:0]  na, nb;
	logic              accept, ld_ok, rd_ok, last_i, last_j;
	logic [PA_W-1:0]   pij, pinb;

	logic              op_we_a, op_we_b;
	logic [WORD_W-1:0] a_rd, b_rd;
	logic              p_clr, p_we, p_re;
	logic [PA_W-1:0]   p_waddr, p_raddr;
	logic [WORD_W-1:0] p_wdata, p_rd;
	mac_ctl_t          mac_ctl;
	logic [WORD_W-1:0] sum_lo, carry;

	assign na     = eff_len(a_words_q);
	assign nb     = eff_len(b_words_q);
	assign accept = start && (state_q == ST_IDLE);
	assign ld_ok  = int'(req.word_index) < MAX_WORDS;
	assign rd_ok  = int'(req.word_index) < PROD_WORDS;
	assign last_i = (i_q == OA_W'(na - LEN_W'(1)));
	assign last_j = (j_q == OA_W'(nb - LEN_W'(1)));
	assign pij    = PA_W'(i_q) + PA_W'(j_q);
	assign pinb   = PA_W'(i_q) + PA_W'(nb);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (req.req_type)
						REQ_LOAD_A, REQ_LOAD_B: state_d = ST_IDLE;
						REQ_MUL: state_d = (na == '0 || nb == '0) ? ST_FIN : ST_FETCH;
						REQ_READ: state_d = ST_READ;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_READ:  state_d = ST_IDLE;
			ST_FETCH: state_d = ST_MULT;
			ST_MULT:  state_d = ST_ACC;
			ST_ACC:   state_d = last_j ? ST_CARRY : ST_FETCH;
			ST_CARRY: state_d = last_i ? ST_FIN : ST_FETCH;
			ST_FIN:   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		op_we_a           = 1'b0;
		op_we_b           = 1'b0;
		p_clr             = 1'b0;
		p_re              = 1'b0;
		p_raddr           = pij;
		p_we              = 1'b0;
		p_waddr           = pij;
		p_wdata           = sum_lo;
		mac_ctl.mul_en    = 1'b0;
		mac_ctl.acc_en    = 1'b0;
		mac_ctl.carry_clr = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				p_raddr = PA_W'(req.word_index);
				if (accept) begin
					op_we_a           = (req.req_type == REQ_LOAD_A) && ld_ok;
					op_we_b           = (req.req_type == REQ_LOAD_B) && ld_ok;
					p_re              = (req.req_type == REQ_READ);
					p_clr             = (req.req_type == REQ_MUL);
					mac_ctl.carry_clr = (req.req_type == REQ_MUL);
				end
			end
			ST_FETCH: p_re = 1'b1;
			ST_MULT:  mac_ctl.mul_en = 1'b1;
			ST_ACC: begin
				mac_ctl.acc_en = 1'b1;
				p_we           = 1'b1;
			end
			ST_CARRY: begin
				p_we              = 1'b1;
				p_waddr           = pinb;
				p_wdata           = carry;
				mac_ctl.carry_clr = 1'b1;
			end
			ST_READ, ST_FIN: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			a_words_q   <= CFG_W'(1);
			b_words_q   <= CFG_W'(1);
			i_q         <= '0;
			j_q         <= '0;
			rd_ok_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == CFG_A_WORDS) begin
					a_words_q <= cfg_wdata;
				end
				if (cfg_index == CFG_B_WORDS) begin
					b_words_q <= cfg_wdata;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						i_q     <= '0;
						j_q     <= '0;
						rd_ok_q <= rd_ok;
						if (req.req_type == REQ_LOAD_A || req.req_type == REQ_LOAD_B) begin
							rsp_valid_q <= 1'b1;
						end
					end
				end
				ST_READ: rsp_valid_q <= 1'b1;
				ST_ACC: j_q <= last_j ? '0 : j_q + OA_W'(1);
				ST_CARRY: begin
					if (!last_i) begin
						i_q <= i_q + OA_W'(1);
					end
				end
				ST_FIN: rsp_valid_q <= 1'b1;
				ST_FETCH, ST_MULT: begin
				end
				default: begin
				end
			endcase
		end
	end

	// response word payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				rsp_q.result_word <= '0;
				rsp_q.done_res    <= ld_ok;
			end
			ST_READ: begin
				rsp_q.result_word <= rd_ok_q ? p_rd : '0;
				rsp_q.done_res    <= rd_ok_q;
			end
			ST_FIN: begin
				rsp_q.result_word <= '0;
				rsp_q.done_res    <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign busy      = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	mim_opnd_store u_opnd (
		.clk     (clk),
		.we_a    (op_we_a),
		.we_b    (op_we_b),
		.waddr   (OA_W'(req.word_index)),
		.wdata   (req.word_value),
		.raddr_a (i_q),
		.raddr_b (j_q),
		.rdata_a (a_rd),
		.rdata_b (b_rd)
	);

	mim_prod_store u_prod (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (p_clr),
		.we     (p_we),
		.waddr  (p_waddr),
		.wdata  (p_wdata),
		.re     (p_re),
		.raddr  (p_raddr),
		.rdata  (p_rd)
	);

	mim_mac u_mac (
		.clk    (clk),
		.ctl    (mac_ctl),
		.a_word (a_rd),
		.b_word (b_rd),
		.p_word (p_rd),
		.sum_lo (sum_lo),
		.carry  (carry)
	);

`ifndef SYNTH
	a_no_rsp_mid_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MULT || state_q == ST_ACC || state_q == ST_CARRY) |-> !rsp_valid)
		else $error("response strobe during multiply");

	a_carry_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CARRY) |-> (int'(p_waddr) < int'(na) + int'(nb)))
		else $error("carry write past product end");

	a_fin_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |=> (rsp_valid && rsp.done_res && rsp.result_word == '0))
		else $error("multiply did not answer done");

	a_carry_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.req_type == REQ_MUL) |=> (carry == '0))
		else $error("carry not cleared at multiply start");
`endif

endmodule
